// ----- design/tactile_sample_calibrator_unit_macros.svh -----
// assertion macros for the tactile sample calibrator
// used by the top level only; expects a clock named clk and reset rst_n in scope
`ifndef TACTILE_SAMPLE_CALIBRATOR_UNIT_MACROS_SVH
`define TACTILE_SAMPLE_CALIBRATOR_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define TSCU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define TSCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tscu_pkg.sv -----
// shared types, codes and widths for the tactile sample calibrator
// no dependencies; used by every module of the block
package tscu_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int FULL_BITS   = 16;
    localparam int KIND_BITS   = 2;
    localparam int OUT_BITS    = FRAC_BITS + 2;
    // one extra bit so the magnitude of the most negative sample fits
    localparam int NUM_BITS    = SAMPLE_BITS + 1;
    localparam int DVD_BITS    = NUM_BITS + FRAC_BITS;
    localparam int DIV_STEPS   = DVD_BITS;
    localparam int REG_IDX_BITS = 2;

    // register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_FULL_SCALE  = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SENSOR_KIND = 2'd1;

    // sensor kinds
    localparam logic [KIND_BITS-1:0] KIND_INVERTED = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_FABRIC   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_PLAIN    = 2'd2;

    // reset values
    localparam logic [FULL_BITS-1:0] FULL_SCALE_RESET  = 16'd4095;
    localparam logic [KIND_BITS-1:0] SENSOR_KIND_RESET = KIND_PLAIN;

    // fixed-point landmarks
    localparam logic [OUT_BITS-1:0] ONE_CODE = OUT_BITS'(1) << FRAC_BITS;
    localparam logic [OUT_BITS-1:0] MAX_CODE = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] MIN_CODE = {1'b1, {(OUT_BITS-1){1'b0}}};

    // per-item sideband that rides along the divider
    typedef struct packed {
        logic                 zero_full;
        logic [KIND_BITS-1:0] kind;
        logic                 force_one;
        logic                 neg;
    } tscu_side_t;

    // contents of one divider cell
    typedef struct packed {
        logic [FULL_BITS-1:0] rem;
        logic [DVD_BITS-1:0]  dvd;
        logic [OUT_BITS-1:0]  quo;
        logic                 ovf;
        logic [FULL_BITS-1:0] den;
        tscu_side_t           side;
    } tscu_cell_t;

endpackage

// ----- design/tscu_prep.sv -----
// front end: turns a raw sample and the configuration into a division job
// depends on tscu_pkg
module tscu_prep (
    input  logic signed [tscu_pkg::SAMPLE_BITS-1:0] raw_sample,
    input  logic [tscu_pkg::FULL_BITS-1:0]          full_scale,
    input  logic [tscu_pkg::KIND_BITS-1:0]          sensor_kind,
    output tscu_pkg::tscu_cell_t                    job
);

    logic signed [tscu_pkg::SAMPLE_BITS:0] raw_ext;
    logic signed [tscu_pkg::SAMPLE_BITS:0] full_ext;
    logic [tscu_pkg::SAMPLE_BITS:0]        diff;
    logic [tscu_pkg::SAMPLE_BITS:0]        mag;
    logic [tscu_pkg::FULL_BITS-1:0]        r_clamp;
    logic [tscu_pkg::FULL_BITS-1:0]        rest;
    logic [tscu_pkg::NUM_BITS-1:0]         num;
    logic [tscu_pkg::FULL_BITS-1:0]        den;
    logic                                  force_one;
    logic                                  neg;
    logic [tscu_pkg::KIND_BITS-1:0]        kind;

    assign raw_ext  = (tscu_pkg::SAMPLE_BITS+1)'(raw_sample);
    assign full_ext = $signed({1'b0, full_scale});
    assign diff     = $unsigned(full_ext - raw_ext);
    assign mag      = raw_sample[tscu_pkg::SAMPLE_BITS-1] ? $unsigned(-raw_ext)
                                                          : $unsigned(raw_ext);

    // fabric clamp to [0, full-1]
    always_comb
    begin
        if (raw_sample[tscu_pkg::SAMPLE_BITS-1])
        begin
            r_clamp = '0;
        end
        else if (raw_ext >= full_ext)
        begin
            r_clamp = full_scale - tscu_pkg::FULL_BITS'(1);
        end
        else
        begin
            r_clamp = tscu_pkg::FULL_BITS'($unsigned(raw_ext));
        end
    end

    assign rest = full_scale - r_clamp;

    // numerator, denominator and flags per kind
    always_comb
    begin
        num       = '0;
        den       = full_scale;
        force_one = 1'b0;
        neg       = 1'b0;
        kind      = tscu_pkg::KIND_PLAIN;
        case (sensor_kind)
            tscu_pkg::KIND_INVERTED:
            begin
                kind = tscu_pkg::KIND_INVERTED;
                if ((raw_ext > 0) && (raw_ext < full_ext))
                begin
                    num = diff[tscu_pkg::NUM_BITS-1:0];
                end
            end
            tscu_pkg::KIND_FABRIC:
            begin
                kind = tscu_pkg::KIND_FABRIC;
                den  = rest;
                if (r_clamp >= rest)
                begin
                    force_one = 1'b1;
                end
                else
                begin
                    num = tscu_pkg::NUM_BITS'(r_clamp);
                end
            end
            default:
            begin
                kind = tscu_pkg::KIND_PLAIN;
                neg  = raw_sample[tscu_pkg::SAMPLE_BITS-1];
                num  = mag[tscu_pkg::NUM_BITS-1:0];
            end
        endcase
    end

    // dividend is the numerator shifted up by the fraction bits
    always_comb
    begin
        job                = '0;
        job.dvd            = {num, {tscu_pkg::FRAC_BITS{1'b0}}};
        job.den            = den;
        job.side.zero_full = (full_scale == '0);
        job.side.kind      = kind;
        job.side.force_one = force_one;
        job.side.neg       = neg;
    end

endmodule

// ----- design/tscu_div_cell.sv -----
// one restoring division step: one quotient bit per cell, handed to the next cell
// depends on tscu_pkg
module tscu_div_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 prev_valid,
    input  tscu_pkg::tscu_cell_t prev_cell,
    output logic                 valid_reg,
    output tscu_pkg::tscu_cell_t cell_reg
);

    logic [tscu_pkg::FULL_BITS:0]   rem_shift;
    logic [tscu_pkg::FULL_BITS:0]   rem_diff;
    logic                           q_bit;
    tscu_pkg::tscu_cell_t           cell_next;

    // bring down the next dividend bit and try the subtract
    assign rem_shift = {prev_cell.rem, prev_cell.dvd[tscu_pkg::DVD_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, prev_cell.den};
    assign q_bit     = (rem_shift >= {1'b0, prev_cell.den});

    always_comb
    begin
        cell_next      = prev_cell;
        cell_next.rem  = q_bit ? rem_diff[tscu_pkg::FULL_BITS-1:0]
                               : rem_shift[tscu_pkg::FULL_BITS-1:0];
        cell_next.dvd  = {prev_cell.dvd[tscu_pkg::DVD_BITS-2:0], 1'b0};
        cell_next.quo  = {prev_cell.quo[tscu_pkg::OUT_BITS-2:0], q_bit};
        cell_next.ovf  = prev_cell.ovf | prev_cell.quo[tscu_pkg::OUT_BITS-1];
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cell_reg <= cell_next;
        end
    end

endmodule

// ----- design/tscu_finish.sv -----
// back end: saturation, sign and special cases, then the output register
// depends on tscu_pkg
module tscu_finish (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                last_valid,
    input  tscu_pkg::tscu_cell_t                last_cell,
    output logic                                out_valid_reg,
    output logic signed [tscu_pkg::OUT_BITS-1:0] calibrated_reg,
    output logic                                saturated_reg
);

    logic [tscu_pkg::OUT_BITS-1:0] quo;
    logic                          ovf;
    logic                          above_two;
    logic [tscu_pkg::OUT_BITS-1:0] calibrated_next;
    logic                          saturated_next;

    assign quo = last_cell.quo;
    assign ovf = last_cell.ovf;
    // quotient strictly above 2.0
    assign above_two = ovf
                     | (quo[tscu_pkg::OUT_BITS-1] & (|quo[tscu_pkg::OUT_BITS-2:0]));

    // result selection
    always_comb
    begin
        calibrated_next = quo;
        saturated_next  = 1'b0;
        if (last_cell.side.zero_full)
        begin
            calibrated_next = '0;
            saturated_next  = 1'b1;
        end
        else
        begin
            case (last_cell.side.kind)
                tscu_pkg::KIND_INVERTED:
                begin
                    calibrated_next = quo;
                end
                tscu_pkg::KIND_FABRIC:
                begin
                    calibrated_next = last_cell.side.force_one ? tscu_pkg::ONE_CODE : quo;
                end
                default:
                begin
                    if (last_cell.side.neg)
                    begin
                        if (above_two)
                        begin
                            calibrated_next = tscu_pkg::MIN_CODE;
                            saturated_next  = 1'b1;
                        end
                        else
                        begin
                            calibrated_next = -quo;
                        end
                    end
                    else if (ovf || quo[tscu_pkg::OUT_BITS-1])
                    begin
                        calibrated_next = tscu_pkg::MAX_CODE;
                        saturated_next  = 1'b1;
                    end
                end
            endcase
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= last_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            calibrated_reg <= $signed(calibrated_next);
            saturated_reg  <= saturated_next;
        end
    end

endmodule

// ----- design/tactile_sample_calibrator_unit.sv -----
// top level of the tactile sample calibrator: config registers, divider chain, output
// depends on tscu_pkg, tscu_prep, tscu_div_cell, tscu_finish and the macros header
//
// Takes one raw tactile sample per beat and returns one calibrated value with 16
// fraction bits in [-2, 2), plus a saturation flag. The quotient comes from a chain
// of 33 restoring division cells, one quotient bit per cell (a 17-bit magnitude
// shifted up by 16 fraction bits), so a new sample is accepted every cycle unless
// the chain is stalled; each sample passes through the 33 cells and then the output
// register, the first cell loading on the accepting edge. The whole chain moves
// together: it holds only while a finished result waits at the output under stall,
// and in_stall follows that condition. Configuration is written through wr_en,
// wr_index and wr_data; full_scale resets to 4095 and sensor_kind to plain
// normalization. A zero full scale gives 0 with the flag set.
`include "tactile_sample_calibrator_unit_macros.svh"

module tactile_sample_calibrator_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    wr_en,
    input  logic [tscu_pkg::REG_IDX_BITS-1:0]       wr_index,
    input  logic [tscu_pkg::FULL_BITS-1:0]          wr_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [tscu_pkg::SAMPLE_BITS-1:0] raw_sample,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [tscu_pkg::OUT_BITS-1:0]    calibrated,
    output logic                                    saturated
);

    logic [tscu_pkg::FULL_BITS-1:0] full_scale_reg;
    logic [tscu_pkg::KIND_BITS-1:0] sensor_kind_reg;
    logic                           advance;
    tscu_pkg::tscu_cell_t           job;
    logic                           cell_valid [0:tscu_pkg::DIV_STEPS];
    tscu_pkg::tscu_cell_t           cell_data  [0:tscu_pkg::DIV_STEPS];
    logic                           out_valid_reg;
    logic signed [tscu_pkg::OUT_BITS-1:0] calibrated_reg;
    logic                           saturated_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg  <= tscu_pkg::FULL_SCALE_RESET;
            sensor_kind_reg <= tscu_pkg::SENSOR_KIND_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == tscu_pkg::REG_FULL_SCALE)
            begin
                full_scale_reg <= wr_data;
            end
            else if (wr_index == tscu_pkg::REG_SENSOR_KIND)
            begin
                sensor_kind_reg <= wr_data[tscu_pkg::KIND_BITS-1:0];
            end
        end
    end

    // chain moves unless a finished result is held at the output
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // job setup
    tscu_prep u_prep (
        .raw_sample  (raw_sample),
        .full_scale  (full_scale_reg),
        .sensor_kind (sensor_kind_reg),
        .job         (job)
    );

    assign cell_valid[0] = in_valid;
    assign cell_data[0]  = job;

    // division cells
    for (genvar i = 0; i < tscu_pkg::DIV_STEPS; i++)
    begin : g_cell
        tscu_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (cell_valid[i]),
            .prev_cell  (cell_data[i]),
            .valid_reg  (cell_valid[i+1]),
            .cell_reg   (cell_data[i+1])
        );
    end

    // result fixup and output register
    tscu_finish u_finish (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .last_valid     (cell_valid[tscu_pkg::DIV_STEPS]),
        .last_cell      (cell_data[tscu_pkg::DIV_STEPS]),
        .out_valid_reg  (out_valid_reg),
        .calibrated_reg (calibrated_reg),
        .saturated_reg  (saturated_reg)
    );

    assign out_valid  = out_valid_reg;
    assign calibrated = calibrated_reg;
    assign saturated  = saturated_reg;

    // checks
    `TSCU_ASSERT_NOW(a_stall_only_when_held, in_stall, out_valid && out_stall,
        "input stalled while output is free")
    `TSCU_ASSERT_NOW(a_sat_value, out_valid && saturated,
        calibrated == '0 || calibrated == $signed(tscu_pkg::MAX_CODE)
            || calibrated == $signed(tscu_pkg::MIN_CODE),
        "saturated result is not a limit or zero")
    `TSCU_ASSERT_NEXT(a_last_cell_reaches_out, advance && cell_valid[tscu_pkg::DIV_STEPS],
        out_valid, "result from last cell lost")

endmodule

// ----- test/tb_tactile_sample_calibrator_unit.sv -----
// testbench for tactile_sample_calibrator_unit: directed table, then random samples under changing settings
// depends on tscu_pkg and the top level; checks every result beat against typed expectations or a built-in predictor
`timescale 1ns / 100ps

module tb_tactile_sample_calibrator_unit;

    import tscu_pkg::*;

    localparam int    HOLD_CYCLES   = 300;
    localparam int    CYCLE_LIMIT   = 200000;
    localparam int    PIPE_LATENCY  = 33;
    localparam int    RANDOM_BLOCKS = 14;
    localparam int    BLOCK_ITEMS   = 50;
    localparam longint LIMIT_MAG    = longint'(1) <<< (FRAC_BITS + 1);

    // index with no register behind it, writes must be ignored
    localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 2'd2;
    // kind code three behaves like plain normalization
    localparam logic [KIND_BITS-1:0]    KIND_SPARE = 2'd3;
    localparam logic [OUT_BITS-1:0]     MINUS_ONE  = 18'h30000;

    typedef struct packed {
        logic [OUT_BITS-1:0] cal;
        logic                sat;
    } calib_t;

    typedef struct packed {
        logic [FULL_BITS-1:0]   full;
        logic [KIND_BITS-1:0]   kind;
        logic [SAMPLE_BITS-1:0] raw;
        logic                   known;
        logic [OUT_BITS-1:0]    cal;
        logic                   sat;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 25;

    // full, kind, raw, expected typed in, calibrated, saturated
    directed_row_t directed_table [DIRECTED_ROWS] = '{
        '{16'd4095,  KIND_PLAIN,    16'd0,          1'b1, '0,        1'b0},
        '{16'd4095,  KIND_PLAIN,    16'd4095,       1'b1, ONE_CODE,  1'b0},
        '{16'd4095,  KIND_PLAIN,    16'(-4095),     1'b1, MINUS_ONE, 1'b0},
        '{16'd4095,  KIND_PLAIN,    16'h7FFF,       1'b1, MAX_CODE,  1'b1},
        '{16'd4095,  KIND_PLAIN,    16'h8000,       1'b1, MIN_CODE,  1'b1},
        '{16'd1,     KIND_PLAIN,    16'(-2),        1'b1, MIN_CODE,  1'b0},
        '{16'd1,     KIND_PLAIN,    16'd1,          1'b1, ONE_CODE,  1'b0},
        '{16'd1,     KIND_PLAIN,    16'(-3),        1'b1, MIN_CODE,  1'b1},
        '{16'd65535, KIND_PLAIN,    16'h7FFF,       1'b0, '0,        1'b0},
        '{16'd65535, KIND_PLAIN,    16'hFFFF,       1'b0, '0,        1'b0},
        '{16'd0,     KIND_PLAIN,    16'd100,        1'b1, '0,        1'b1},
        '{16'd0,     KIND_INVERTED, 16'(-5),        1'b1, '0,        1'b1},
        '{16'd0,     KIND_FABRIC,   16'd7,          1'b1, '0,        1'b1},
        '{16'd1000,  KIND_INVERTED, 16'd0,          1'b1, '0,        1'b0},
        '{16'd1000,  KIND_INVERTED, 16'd1000,       1'b1, '0,        1'b0},
        '{16'd1000,  KIND_INVERTED, 16'hFFFF,       1'b1, '0,        1'b0},
        '{16'd1000,  KIND_INVERTED, 16'd1,          1'b0, '0,        1'b0},
        '{16'd1000,  KIND_INVERTED, 16'd999,        1'b0, '0,        1'b0},
        '{16'd1000,  KIND_FABRIC,   16'h8000,       1'b1, '0,        1'b0},
        '{16'd1000,  KIND_FABRIC,   16'd500,        1'b1, ONE_CODE,  1'b0},
        '{16'd1000,  KIND_FABRIC,   16'h7FFF,       1'b1, ONE_CODE,  1'b0},
        '{16'd1000,  KIND_FABRIC,   16'd499,        1'b0, '0,        1'b0},
        '{16'd65535, KIND_FABRIC,   16'h7FFF,       1'b0, '0,        1'b0},
        '{16'd300,   KIND_SPARE,    16'(-150),      1'b0, '0,        1'b0},
        '{16'd65535, KIND_INVERTED, 16'h7FFF,       1'b0, '0,        1'b0}
    };

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          wr_en      = 1'b0;
    logic [REG_IDX_BITS-1:0]       wr_index   = '0;
    logic [FULL_BITS-1:0]          wr_data    = '0;
    logic                          in_valid   = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] raw_sample = '0;
    logic                          out_valid;
    logic                          out_stall  = 1'b0;
    logic signed [OUT_BITS-1:0]    calibrated;
    logic                          saturated;

    // predictor's copy of the configuration
    logic [FULL_BITS-1:0] model_full = FULL_SCALE_RESET;
    logic [KIND_BITS-1:0] model_kind = SENSOR_KIND_RESET;

    calib_t pending_values [$];
    int     mismatches      = 0;
    int     samples_sent    = 0;
    int     results_checked = 0;
    int     settings_used   = 0;
    int     cycles          = 0;
    int     stall_pct       = 0;
    int     hold_asks       = 0;
    int     hold_seen       = 0;
    int     hold_left       = 0;

    tactile_sample_calibrator_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_sample (raw_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .calibrated (calibrated),
        .saturated  (saturated)
    );

    always #5 clk = ~clk;

    // calibrated value and flag for one sample under the given settings
    function automatic calib_t predict_calibration(logic [SAMPLE_BITS-1:0] raw_bits,
                                                   logic [FULL_BITS-1:0] full,
                                                   logic [KIND_BITS-1:0] kind);
        longint raw;
        longint fs;
        longint r;
        longint rest;
        longint mag;
        longint q;
        calib_t res;
        raw = longint'($signed(raw_bits));
        fs  = longint'(full);
        res.cal = '0;
        res.sat = 1'b0;
        if (fs == 0)
        begin
            res.sat = 1'b1;
        end
        else if (kind == KIND_INVERTED)
        begin
            if (raw > 0 && raw < fs)
                res.cal = OUT_BITS'(((fs - raw) <<< FRAC_BITS) / fs);
        end
        else if (kind == KIND_FABRIC)
        begin
            r = (raw < 0) ? 0 : raw;
            if (r >= fs)
                r = fs - 1;
            rest = fs - r;
            if (r >= rest)
                res.cal = ONE_CODE;
            else
                res.cal = OUT_BITS'((r <<< FRAC_BITS) / rest);
        end
        else
        begin
            mag = (raw < 0) ? -raw : raw;
            q = (mag <<< FRAC_BITS) / fs;
            if (raw < 0)
            begin
                if (q > LIMIT_MAG)
                begin
                    q = LIMIT_MAG;
                    res.sat = 1'b1;
                end
                res.cal = OUT_BITS'(-q);
            end
            else
            begin
                if (q >= LIMIT_MAG)
                begin
                    q = LIMIT_MAG - 1;
                    res.sat = 1'b1;
                end
                res.cal = OUT_BITS'(q);
            end
        end
        return res;
    endfunction

    // raw values biased toward the interesting spots of each curve
    function automatic logic [SAMPLE_BITS-1:0] pick_raw(logic [FULL_BITS-1:0] full);
        int f;
        f = int'(full);
        case ($urandom_range(0, 9))
            0: return SAMPLE_BITS'($urandom);
            1:
            begin
                case ($urandom_range(0, 7))
                    0: return 16'd0;
                    1: return 16'd1;
                    2: return 16'hFFFF;
                    3: return 16'h7FFF;
                    4: return 16'h8000;
                    5: return SAMPLE_BITS'(f);
                    6: return SAMPLE_BITS'(f - 1);
                    default: return SAMPLE_BITS'(f + 1);
                endcase
            end
            2, 3, 4: return SAMPLE_BITS'($urandom_range(0, f));
            5: return SAMPLE_BITS'(f / 2 + $urandom_range(0, 6) - 3);
            6: return SAMPLE_BITS'(-$urandom_range(0, 2 * f + 2));
            7: return SAMPLE_BITS'(2 * f + $urandom_range(0, 4) - 2);
            8: return SAMPLE_BITS'(-2 * f + $urandom_range(0, 4) - 2);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_BITS-1:0] got,
                                   input logic [OUT_BITS-1:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // drive one sample beat, return at the falling edge after it was taken
    task automatic offer_sample(input logic [SAMPLE_BITS-1:0] value, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid   <= 1'b0;
            raw_sample <= SAMPLE_BITS'($urandom);
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        raw_sample <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        samples_sent++;
        @(negedge clk);
    endtask

    // stop sending and wait until every expected value has come back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // both registers, sometimes a stray write to the empty index first
    task automatic set_config(input logic [FULL_BITS-1:0] full, input logic [KIND_BITS-1:0] kind);
        if ($urandom_range(0, 3) == 0)
        begin
            wr_en    <= 1'b1;
            wr_index <= REG_UNUSED;
            wr_data  <= FULL_BITS'($urandom);
            @(negedge clk);
        end
        wr_en    <= 1'b1;
        wr_index <= REG_FULL_SCALE;
        wr_data  <= full;
        @(negedge clk);
        wr_index <= REG_SENSOR_KIND;
        wr_data  <= {14'($urandom), kind};
        @(negedge clk);
        wr_en      <= 1'b0;
        model_full = full;
        model_kind = kind;
        settings_used++;
    endtask

    // receiver: random stall, or a long hold when asked
    always @(negedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // result beat check against the oldest expectation
    always @(posedge clk)
    begin
        calib_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_values.size() == 0)
            begin
                report_mismatch("unexpected result", calibrated, '0);
            end
            else
            begin
                want = pending_values.pop_front();
                if (calibrated !== want.cal)
                    report_mismatch("calibrated", calibrated, want.cal);
                if (saturated !== want.sat)
                    report_mismatch("saturated", OUT_BITS'(saturated), OUT_BITS'(want.sat));
                results_checked++;
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [FULL_BITS-1:0]   full;
        logic [KIND_BITS-1:0]   kind;
        logic [SAMPLE_BITS-1:0] value;
        int                     idle_pct;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, config changes only between groups
        foreach (directed_table[i])
        begin
            if (directed_table[i].full != model_full || directed_table[i].kind != model_kind)
            begin
                wait_all_results();
                set_config(directed_table[i].full, directed_table[i].kind);
            end
            offer_sample(directed_table[i].raw, 0);
            if (directed_table[i].known)
                pending_values.push_back('{directed_table[i].cal, directed_table[i].sat});
            else
                pending_values.push_back(predict_calibration(directed_table[i].raw,
                                                             model_full, model_kind));
        end

        // random blocks, each under its own setting and idling phase
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            wait_all_results();
            case (blk)
                0: full = 16'd65535;
                1: full = 16'd1;
                default:
                begin
                    case ($urandom_range(0, 7))
                        0: full = 16'd1;
                        1: full = 16'd65535;
                        2: full = 16'd0;
                        3: full = FULL_BITS'($urandom_range(1, 255));
                        4: full = FULL_BITS'($urandom_range(256, 4095));
                        5: full = FULL_BITS'($urandom_range(4096, 65535));
                        6: full = 16'h8000;
                        default: full = FULL_BITS'($urandom_range(1, 65535));
                    endcase
                end
            endcase
            kind = (blk < 4) ? KIND_BITS'(blk) : KIND_BITS'($urandom_range(0, 3));
            set_config(full, kind);

            case (blk % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 52;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 52;
                end
                default:
                begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase

            // long receiver hold while the sender keeps pushing
            if (blk == 5)
            begin
                idle_pct = 0;
                hold_asks++;
            end

            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                // sender pause until the pipe has drained
                if (blk == 9 && n == BLOCK_ITEMS / 2)
                    wait_all_results();
                value = pick_raw(model_full);
                offer_sample(value, idle_pct);
                pending_values.push_back(predict_calibration(value, model_full, model_kind));
            end
        end

        wait_all_results();
        stall_pct = 0;
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (pending_values.size() != 0)
            report_mismatch("results left over", OUT_BITS'(pending_values.size()), '0);

        $display("%0d samples sent over %0d settings, %0d results checked, %0d mismatches",
                 samples_sent, settings_used, results_checked, mismatches);
        $display("all sensor kinds, zero and extreme full scales, and every idling mix were run");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/tscu_pkg.sv
design/tscu_prep.sv
design/tscu_div_cell.sv
design/tscu_finish.sv
design/tactile_sample_calibrator_unit.sv
test/tb_tactile_sample_calibrator_unit.sv
